@@ design/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
// No dependencies; imported by every other file of the block.
package bole_pkg;

	localparam int unsigned BOLE_DEPTH = 64;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned POS_W      = 8;
	localparam int unsigned OPC_W      = 3;
	localparam int unsigned ST_W       = 3;
	localparam int unsigned CNT_OUT_W  = 7;

	typedef enum logic [OPC_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_DEL_VAL   = 3'd6
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_DECIDE,
		CMD_INS_RD,
		CMD_INS_WR,
		CMD_DEL_RD,
		CMD_DEL_CHK,
		CMD_SH_RD,
		CMD_SH_WR,
		CMD_FIN
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
	} dp_cmd_t;

	// flags returned by the datapath
	typedef struct packed {
		logic dec_err;   // decided request fails (full, empty, bad position)
		logic dec_ins;   // decided request is an insert
		logic dec_nop;   // unused opcode
		logic ins_more;  // insert still has entries to move up
		logic sh_more;   // pointer is not the last used entry
		logic match;     // read entry equals the request value
		logic delval;    // current request is delete by value
	} dp_stat_t;

endpackage

@@ design/bole_req_if.sv @@
// Request channel of the bounded ordered list engine: valid/ready plus payload.
// Depends on bole_pkg.
interface bole_req_if;
	import bole_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

@@ design/bole_rsp_if.sv @@
// Response channel of the bounded ordered list engine: valid/ready plus payload.
// Depends on bole_pkg.
interface bole_rsp_if;
	import bole_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] removed_value;
	logic [ST_W-1:0]         status;
	logic [CNT_OUT_W-1:0]    count;

	modport source (output valid, output removed_value, output status, output count,
		input ready);
	modport sink   (input valid, input removed_value, input status, input count,
		output ready);
endinterface

@@ design/bole_ctrl.sv @@
// Controller of the bounded ordered list engine: one-hot sequencer and
// response valid flag. Depends on bole_pkg; drives bole_dp by command struct.
module bole_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bole_pkg::dp_stat_t stat,
	output bole_pkg::dp_cmd_t  cmd
);
	import bole_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_DECIDE  = 9'b000000010,
		S_INS_RD  = 9'b000000100,
		S_INS_WR  = 9'b000001000,
		S_DEL_RD  = 9'b000010000,
		S_DEL_CHK = 9'b000100000,
		S_SH_RD   = 9'b001000000,
		S_SH_WR   = 9'b010000000,
		S_FIN     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.op    = CMD_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = CMD_LATCH;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op = CMD_DECIDE;
				if (stat.dec_nop || stat.dec_err) begin
					state_d = S_FIN;
				end else if (stat.dec_ins) begin
					state_d = S_INS_RD;
				end else begin
					state_d = S_DEL_RD;
				end
			end
			S_INS_RD: begin
				cmd.op  = CMD_INS_RD;
				state_d = stat.ins_more ? S_INS_WR : S_FIN;
			end
			S_INS_WR: begin
				cmd.op  = CMD_INS_WR;
				state_d = S_INS_RD;
			end
			S_DEL_RD: begin
				cmd.op  = CMD_DEL_RD;
				state_d = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				cmd.op = CMD_DEL_CHK;
				if (!stat.delval || stat.match) begin
					state_d = S_SH_RD;
				end else if (!stat.sh_more) begin
					state_d = S_FIN;
				end else begin
					state_d = S_DEL_RD;
				end
			end
			S_SH_RD: begin
				cmd.op  = CMD_SH_RD;
				state_d = stat.sh_more ? S_SH_WR : S_FIN;
			end
			S_SH_WR: begin
				cmd.op  = CMD_SH_WR;
				state_d = S_SH_RD;
			end
			S_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.op  = CMD_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == CMD_FIN) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && !rsp_ready |=> state_q == S_FIN)
		else $error("result dropped while response slot busy");

	a_err_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECIDE && stat.dec_err |=> state_q == S_FIN)
		else $error("failed request entered a list sweep");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_WR || state_q == S_SH_WR |->
			$past(state_q) == S_INS_RD || $past(state_q) == S_SH_RD)
		else $error("entry write without preceding read");

endmodule

@@ design/bole_dp.sv @@
// Datapath of the bounded ordered list engine: request decode, entry memory,
// sweep pointer, count and response registers. Depends on bole_pkg.
module bole_dp #(
	parameter int unsigned DEPTH = bole_pkg::BOLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bole_pkg::dp_cmd_t                cmd,
	output bole_pkg::dp_stat_t               stat,
	input  logic [bole_pkg::OPC_W-1:0]       in_opcode,
	input  logic signed [bole_pkg::VAL_W-1:0] in_value,
	input  logic [bole_pkg::POS_W-1:0]       in_position,
	output logic signed [bole_pkg::VAL_W-1:0] out_removed,
	output logic [bole_pkg::ST_W-1:0]        out_status,
	output logic [bole_pkg::CNT_OUT_W-1:0]   out_count
);
	import bole_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	// entry memory, position 1 at address 0
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic             we, re;
	logic [AW-1:0]    waddr, raddr;
	logic [VAL_W-1:0] wdata;

	logic [OPC_W-1:0] op_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    cnt_q, ptr_q, idx_q;
	logic             delval_q;
	status_t          status_q;
	logic [VAL_W-1:0] removed_q;

	logic [VAL_W-1:0]     res_removed_q;
	status_t              res_status_q;
	logic [CNT_OUT_W-1:0] res_count_q;

	status_t       dec_status;
	logic [CW-1:0] dec_idx;
	logic          dec_ins, dec_nop;
	logic [XW-1:0] pos_x, cnt_x;
	logic          full, empty;
	logic [CW-1:0] ptr_m1, ptr_p1;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(cnt_q);
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign ptr_m1 = ptr_q - CW'(1);
	assign ptr_p1 = ptr_q + CW'(1);

	// request decode against the current count
	always_comb begin
		dec_status = ST_OK;
		dec_idx    = '0;
		dec_ins    = 1'b0;
		dec_nop    = 1'b0;
		unique case (op_q) inside
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				dec_ins = 1'b1;
				if (full) begin
					dec_status = ST_FULL;
				end else if (op_q == OP_INS_FRONT) begin
					dec_idx = '0;
				end else if (op_q == OP_INS_BACK) begin
					dec_idx = cnt_q;
				end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_idx = CW'(pos_x - XW'(1));
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_VAL: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (op_q == OP_DEL_BACK) begin
					dec_idx = cnt_q - CW'(1);
				end else if (op_q == OP_DEL_POS) begin
					if (pos_x == '0 || pos_x > cnt_x) begin
						dec_status = ST_BADPOS;
					end else begin
						dec_idx = CW'(pos_x - XW'(1));
					end
				end else begin
					dec_idx = '0;
				end
			end
			default: begin
				dec_nop = 1'b1;
			end
		endcase
	end

	assign stat.dec_err  = (dec_status != ST_OK);
	assign stat.dec_ins  = dec_ins;
	assign stat.dec_nop  = dec_nop;
	assign stat.ins_more = (ptr_q > idx_q);
	assign stat.sh_more  = ({1'b0, ptr_q} + (CW+1)'(1)) < {1'b0, cnt_q};
	assign stat.match    = (rdata_q == val_q);
	assign stat.delval   = delval_q;

	// memory port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = ptr_q[AW-1:0];
		raddr = ptr_q[AW-1:0];
		wdata = rdata_q;
		case (cmd.op)
			CMD_INS_RD: begin
				if (stat.ins_more) begin
					re    = 1'b1;
					raddr = ptr_m1[AW-1:0];
				end else begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = val_q;
				end
			end
			CMD_INS_WR: we = 1'b1;
			CMD_DEL_RD: re = 1'b1;
			CMD_SH_RD: begin
				if (stat.sh_more) begin
					re    = 1'b1;
					raddr = ptr_p1[AW-1:0];
				end
			end
			CMD_SH_WR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// count and request class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			delval_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_DECIDE: delval_q <= (op_q == OP_DEL_VAL);
				CMD_INS_RD: if (!stat.ins_more) cnt_q <= cnt_q + CW'(1);
				CMD_SH_RD:  if (!stat.sh_more) cnt_q <= cnt_q - CW'(1);
				default: ;
			endcase
		end
	end

	// request payload, sweep pointer and response
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LATCH: begin
				op_q      <= in_opcode;
				val_q     <= in_value;
				pos_q     <= in_position;
				removed_q <= '0;
				status_q  <= ST_OK;
			end
			CMD_DECIDE: begin
				status_q <= dec_status;
				idx_q    <= dec_idx;
				ptr_q    <= dec_ins ? cnt_q : dec_idx;
			end
			CMD_INS_WR: ptr_q <= ptr_m1;
			CMD_DEL_CHK: begin
				if (!delval_q || stat.match) begin
					removed_q <= rdata_q;
				end else begin
					ptr_q <= ptr_p1;
					if (!stat.sh_more) begin
						status_q <= ST_NOTFOUND;
					end
				end
			end
			CMD_SH_WR: ptr_q <= ptr_p1;
			CMD_FIN: begin
				res_removed_q <= removed_q;
				res_status_q  <= status_q;
				res_count_q   <= CNT_OUT_W'(cnt_q);
			end
			default: ;
		endcase
	end

	assign out_removed = res_removed_q;
	assign out_status  = res_status_q;
	assign out_count   = res_count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_cnt_source: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
			$past(cmd.op) == CMD_INS_RD || $past(cmd.op) == CMD_SH_RD)
		else $error("count moved outside an insert or delete end");

	a_ins_bump: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_INS_RD && !stat.ins_more |=> cnt_q == CW'($past(cnt_q) + CW'(1)))
		else $error("insert finished without count increment");

endmodule

@@ design/bounded_ordered_list_engine.sv @@
// Top level of the bounded ordered list engine: binds controller and datapath
// to the request and response channels. Depends on bole_pkg, bole_req_if,
// bole_rsp_if, bole_ctrl and bole_dp.
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    opcode[2:0], value[31:0] signed, position[7:0]
//  rsp      out  rsp.valid/ready    removed_value[31:0] signed, status[2:0], count[6:0]
//
// One request at a time. Error and unused-opcode requests go from the decide step
// straight to the response register. Inserts move later entries up one place, then
// write the new value. Deletes read the target (by value: compare from the front until
// a hit), then move later entries down; a failed search ends after comparing all of them.
// Each moved entry costs a read and a write on the entry memory.
// Reset clears the count, request class and sequencer state; the memory itself is not cleared.
// The response register frees the sequencer; a stalled rsp holds the next request in
// its final state until the slot empties, and req.ready stays low meanwhile.
module bounded_ordered_list_engine #(
	parameter int unsigned DEPTH = bole_pkg::BOLE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	bole_req_if.sink    req,
	bole_rsp_if.source  rsp
);
	import bole_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: decides which step the datapath takes each cycle
	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// list storage, pointer sweep and response registers
	bole_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_opcode   (req.opcode),
		.in_value    (req.value),
		.in_position (req.position),
		.out_removed (rsp.removed_value),
		.out_status  (rsp.status),
		.out_count   (rsp.count)
	);

endmodule

@@ tb/bole_list_checker.sv @@
// Checker for the bounded ordered list engine: watches both channels, keeps its own
// copy of the list and compares every response with the predicted outcome.
// Depends on bole_pkg, bole_req_if and bole_rsp_if.
`timescale 1ns / 1ps
module bole_list_checker (
	input  logic clk,
	input  logic arst_n,
	bole_req_if  req,
	bole_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   list_len
);
	import bole_pkg::*;

	typedef struct packed {
		logic signed [VAL_W-1:0] removed_value;
		status_t                 status;
		logic [CNT_OUT_W-1:0]    count;
	} list_outcome_t;

	// shadow list, position 1 at index 0
	logic signed [VAL_W-1:0] shelf [BOLE_DEPTH];
	int unsigned             fill;
	list_outcome_t           awaited [$];
	int                      mismatches;

	task automatic flag_field(input string what, input logic [VAL_W-1:0] exp_v,
		input logic [VAL_W-1:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
	endtask

	// Apply one request to the shadow list and work out its response.
	task automatic apply_request(input logic [OPC_W-1:0] op,
		input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos,
		output list_outcome_t res);
		int unsigned spot;
		bit          hit;
		res.removed_value = '0;
		res.status        = ST_OK;
		spot              = 0;
		hit               = 1'b0;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				// full is checked ahead of the position
				if (fill >= BOLE_DEPTH) begin
					res.status = ST_FULL;
				end else if (op == OP_INS_POS && (pos == 0 || pos > fill + 1)) begin
					res.status = ST_BADPOS;
				end else begin
					spot = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? fill : pos - 1;
					for (int k = fill; k > spot; k--)
						shelf[k] = shelf[k-1];
					shelf[spot] = val;
					fill++;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_VAL: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					if (op == OP_DEL_VAL) begin
						// first equal entry from the front
						for (int k = 0; k < fill && !hit; k++) begin
							if (shelf[k] == val) begin
								hit  = 1'b1;
								spot = k;
							end
						end
						if (!hit)
							res.status = ST_NOTFOUND;
					end else if (op == OP_DEL_POS) begin
						if (pos == 0 || pos > fill) begin
							res.status = ST_BADPOS;
						end else begin
							hit  = 1'b1;
							spot = pos - 1;
						end
					end else begin
						hit  = 1'b1;
						spot = (op == OP_DEL_FRONT) ? 0 : fill - 1;
					end
					if (hit) begin
						res.removed_value = shelf[spot];
						for (int k = spot; k + 1 < fill; k++)
							shelf[k] = shelf[k+1];
						fill--;
					end
				end
			end
			default: ; // unused opcode: nothing moves
		endcase
		res.count = CNT_OUT_W'(fill);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_outcome_t want;
		if (!arst_n) begin
			fill = 0;
			awaited.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
			list_len   <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with no request outstanding: %h %h %h",
							$realtime, rsp.removed_value, rsp.status, rsp.count);
				end else begin
					want = awaited.pop_front();
					if (rsp.removed_value !== want.removed_value)
						flag_field("removed_value", want.removed_value, rsp.removed_value);
					if (rsp.status !== want.status)
						flag_field("status", VAL_W'(want.status), VAL_W'(rsp.status));
					if (rsp.count !== want.count)
						flag_field("count", VAL_W'(want.count), VAL_W'(rsp.count));
				end
			end
			if (req.valid && req.ready) begin
				apply_request(req.opcode, req.value, req.position, want);
				awaited.push_back(want);
			end
			fail_count <= mismatches;
			pending    <= awaited.size();
			list_len   <= fill;
		end
	end
endmodule

@@ tb/tb_bounded_ordered_list_engine.sv @@
// Top of the bounded ordered list engine testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on bole_pkg, both channel
// interfaces, bounded_ordered_list_engine and bole_list_checker.
`timescale 1ns / 1ps
module tb_bounded_ordered_list_engine;
	import bole_pkg::*;

	// the one opcode the block ignores
	localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

	// watchdog limit on the whole run, far above what the slowest request needs
	localparam int unsigned CYCLE_LIMIT     = 2_000_000;
	localparam int unsigned SETTLE_CYCLES   = 400;
	localparam int unsigned RANDOM_REQUESTS = 1525;

	logic        clk;
	logic        arst_n;
	bit          steady;     // no idling on either side while set
	int          fail_count;
	int          pending;
	int          list_len;
	int unsigned cycles = 0;

	bole_req_if req ();
	bole_rsp_if rsp ();

	bounded_ordered_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bole_list_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.list_len   (list_len)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bounded_ordered_list_engine verification failed");
			$finish;
		end
	end

	// Response side stalls at random, roughly 6 percent of the time, never inside the steady window.
	always @(posedge clk)
		rsp.ready <= steady || ($urandom_range(0, 99) >= 6);

	// Present one request and hold it until the engine takes it. Idle cycles ahead of
	// the request land wherever the engine happens to be in its sequence.
	task automatic issue_request(input logic [OPC_W-1:0] op,
		input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		while (!steady && $urandom_range(0, 99) < 6) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.opcode   <= op;
		req.value    <= val;
		req.position <= pos;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Values: a quarter from the corner cases, a quarter from a narrow band so that
	// duplicates pile up and delete-by-value hits often, the rest anywhere.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			case ($urandom_range(0, 7))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7FFF_FFFF;
				2:       return 32'sh0000_0000;
				3:       return -32'sd1;
				4:       return 32'sh5555_5555;
				5:       return 32'shAAAA_AAAA;
				6:       return 32'sd1;
				default: return 32'sd100;
			endcase
		end
		if (roll < 50)
			return $signed(VAL_W'($urandom_range(0, 8))) - 32'sd4;
		return $urandom;
	endfunction

	// Positions mostly around the live list, which puts both bounds in reach; now and
	// then anywhere in the 8-bit field.
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, list_len + 1));
		return POS_W'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [OPC_W-1:0] op;
		int unsigned      roll;
		bit               filling;

		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.opcode   <= '0;
		req.value    <= '0;
		req.position <= '0;
		filling      = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: every delete on an empty list, insert position bounds,
		// value extremes, delete position bounds, search miss and hit, unused opcode.
		issue_request(OP_DEL_FRONT, 32'sd7, 8'd0);
		issue_request(OP_DEL_BACK, 32'sd7, 8'd0);
		issue_request(OP_DEL_POS, 32'sd7, 8'd1);
		issue_request(OP_DEL_VAL, 32'sd7, 8'd0);
		issue_request(OP_INS_POS, 32'sd9, 8'd0);            // position zero
		issue_request(OP_INS_POS, 32'sd9, 8'd2);            // one past count+1
		issue_request(OP_INS_POS, 32'sh7FFF_FFFF, 8'd1);
		issue_request(OP_INS_FRONT, 32'sh8000_0000, 8'd0);
		issue_request(OP_INS_BACK, 32'sd0, 8'd0);
		issue_request(OP_INS_BACK, -32'sd1, 8'd0);
		issue_request(OP_INS_POS, 32'sd42, 8'd5);           // count+1, appends
		issue_request(OP_INS_POS, 32'sd42, 8'd255);
		issue_request(OP_DEL_POS, 32'sd0, 8'd0);
		issue_request(OP_DEL_POS, 32'sd0, 8'd6);            // count+1 is out of range
		issue_request(OP_DEL_POS, 32'sd0, 8'd1);
		issue_request(OP_DEL_VAL, 32'sd12345, 8'd0);        // not present
		issue_request(OP_DEL_VAL, -32'sd1, 8'd0);
		issue_request(OP_UNUSED, 32'shFFFF_FFFF, 8'd255);
		issue_request(OP_DEL_FRONT, 32'sd0, 8'd0);
		issue_request(OP_DEL_BACK, 32'sd0, 8'd0);
		issue_request(OP_DEL_POS, 32'sd0, 8'd1);            // last entry goes
		issue_request(OP_DEL_VAL, 32'sd42, 8'd0);           // empty again

		// Random part: the list swings between full and empty. Filling favours
		// inserts, draining favours deletes; the swing flips only some time after
		// the list hits a bound, so full and empty errors both turn up.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			steady <= (n >= 400 && n < 700);
			if (n == 900) begin
				// hold off until the engine has answered everything
				req.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			if (filling && list_len >= BOLE_DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = OP_UNUSED;
			else if ((roll < 77) == filling)
				op = OPC_W'($urandom_range(OP_INS_FRONT, OP_INS_POS));
			else
				op = OPC_W'($urandom_range(OP_DEL_FRONT, OP_DEL_VAL));
			issue_request(op, pick_value(), pick_position());
		end
		req.valid <= 1'b0;

		// The checker's pending count is registered, so the last acceptance shows in it late.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("bounded_ordered_list_engine verification clean");
		else
			$display("bounded_ordered_list_engine verification failed");
		$finish;
	end
endmodule
